[sv/stt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Token kinds, error codes, scanner modes and the keyword table.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int KIND_W = 6;
	localparam int ERR_W  = 3;

	// Token kinds outside the keyword range.
	localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd25;
	localparam logic [KIND_W-1:0] K_ARROW   = 6'd26;
	localparam logic [KIND_W-1:0] K_LT      = 6'd27;
	localparam logic [KIND_W-1:0] K_LE      = 6'd28;
	localparam logic [KIND_W-1:0] K_GT      = 6'd29;
	localparam logic [KIND_W-1:0] K_GE      = 6'd30;
	localparam logic [KIND_W-1:0] K_EQ      = 6'd31;
	localparam logic [KIND_W-1:0] K_NE      = 6'd32;
	localparam logic [KIND_W-1:0] K_PLUS    = 6'd33;
	localparam logic [KIND_W-1:0] K_MINUS   = 6'd34;
	localparam logic [KIND_W-1:0] K_STAR    = 6'd35;
	localparam logic [KIND_W-1:0] K_SLASH   = 6'd36;
	localparam logic [KIND_W-1:0] K_RANGE   = 6'd37;
	localparam logic [KIND_W-1:0] K_LPAREN  = 6'd38;
	localparam logic [KIND_W-1:0] K_RPAREN  = 6'd39;
	localparam logic [KIND_W-1:0] K_LBRACK  = 6'd40;
	localparam logic [KIND_W-1:0] K_RBRACK  = 6'd41;
	localparam logic [KIND_W-1:0] K_LBRACE  = 6'd42;
	localparam logic [KIND_W-1:0] K_RBRACE  = 6'd43;
	localparam logic [KIND_W-1:0] K_COMMA   = 6'd44;
	localparam logic [KIND_W-1:0] K_DOT     = 6'd45;
	localparam logic [KIND_W-1:0] K_IDENT   = 6'd46;
	localparam logic [KIND_W-1:0] K_INT     = 6'd47;
	localparam logic [KIND_W-1:0] K_REAL    = 6'd48;
	localparam logic [KIND_W-1:0] K_STRING  = 6'd49;
	localparam logic [KIND_W-1:0] K_SEMI    = 6'd50;
	localparam logic [KIND_W-1:0] K_NEWLINE = 6'd51;
	localparam logic [KIND_W-1:0] K_EOF     = 6'd52;
	localparam logic [KIND_W-1:0] K_ERROR   = 6'd53;

	// Error codes.
	localparam logic [ERR_W-1:0] E_NONE    = 3'd0;
	localparam logic [ERR_W-1:0] E_CHAR    = 3'd1;
	localparam logic [ERR_W-1:0] E_NUMBER  = 3'd2;
	localparam logic [ERR_W-1:0] E_STRING  = 3'd3;
	localparam logic [ERR_W-1:0] E_OPER    = 3'd4;

	// Scanner modes.
	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_INT,
		MODE_INTDOT,
		MODE_REAL,
		MODE_STR,
		MODE_OP,
		MODE_DOT,
		MODE_ERR
	} mode_t;

	// Keyword table, text right-aligned in 64 bits.
	localparam int KW_COUNT = 25;
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		64'("var"), 64'("is"), 64'("if"), 64'("then"), 64'("else"),
		64'("end"), 64'("while"), 64'("for"), 64'("in"), 64'("loop"),
		64'("exit"), 64'("print"), 64'("return"), 64'("or"), 64'("and"),
		64'("xor"), 64'("not"), 64'("int"), 64'("real"), 64'("bool"),
		64'("string"), 64'("func"), 64'("true"), 64'("false"), 64'("none")
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd2, 4'd2, 4'd4, 4'd4, 4'd3, 4'd5, 4'd3, 4'd2, 4'd4,
		4'd4, 4'd5, 4'd6, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4,
		4'd6, 4'd4, 4'd4, 4'd5, 4'd4
	};

	// Keyword number for an identifier, or the identifier kind.
	function automatic logic [KIND_W-1:0] kw_kind(input logic [63:0] text,
			input logic [3:0] len);
		logic [KIND_W-1:0] k;
		k = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if (KW_LEN[i] == len && KW_TEXT[i] == text) begin
				k = KIND_W'(i);
			end
		end
		return k;
	endfunction

endpackage
`default_nettype wire

[sv/stt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_front: character scanner
// Classifies each accepted byte, keeps the pending token and produces the
// zero, one or two tokens that the byte completes.
// ----------------------------------------------------------------------------
module stt_front #(
	parameter int OFFSET_BITS   = 24,
	parameter int LENGTH_BITS   = 16,
	parameter int KEYWORD_CHARS = 6,
	parameter int TOK_W         = stt_pkg::KIND_W + OFFSET_BITS + LENGTH_BITS
		+ stt_pkg::ERR_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_accept,
	input  wire logic [7:0]       char_byte,
	input  wire logic             end_of_source,
	output logic                  push,
	output logic [1:0]            push_cnt,
	output logic [TOK_W-1:0]      push_tok0,
	output logic [TOK_W-1:0]      push_tok1
);
	import stt_pkg::*;

	localparam int PFX_W = 8 * KEYWORD_CHARS;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	mode_t                  mode_q, mode_d;
	logic [7:0]             held_q, held_d;
	logic [PFX_W-1:0]       prefix_q, prefix_d;
	logic [LENGTH_BITS-1:0] plen_q, plen_d;
	logic [OFFSET_BITS-1:0] pstart_q, pstart_d;
	logic [OFFSET_BITS-1:0] off_q, off_d;

	logic [7:0]       c;
	logic             is_dig, is_alp;
	logic             fl_v, id_v, a_v, b_v, take_idle;
	logic [TOK_W-1:0] fl_tok, id_tok, a_tok, b_tok;
	mode_t            id_mode;
	logic [KIND_W-1:0] pair_k;
	logic             pair_v;
	logic [LENGTH_BITS-1:0] plen1, plen2;

	function automatic logic [TOK_W-1:0] mk(input logic [KIND_W-1:0] k,
			input logic [OFFSET_BITS-1:0] s, input logic [LENGTH_BITS-1:0] l,
			input logic [ERR_W-1:0] e);
		return {e, l, s, k};
	endfunction

	function automatic logic [LENGTH_BITS-1:0] sat(input logic [LENGTH_BITS-1:0] x,
			input logic [1:0] d);
		logic [LENGTH_BITS:0] s;
		s = {1'b0, x} + (LENGTH_BITS+1)'(d);
		return s[LENGTH_BITS] ? LEN_MAX : s[LENGTH_BITS-1:0];
	endfunction

	function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] a);
		logic [KIND_W-1:0] k;
		case (a)
			"<": k = K_LT;
			">": k = K_GT;
			"=": k = K_EQ;
			default: k = K_SLASH;
		endcase
		return k;
	endfunction

	assign c      = char_byte;
	assign is_dig = (c >= "0") && (c <= "9");
	assign is_alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	assign plen1  = sat(plen_q, 2'd1);
	assign plen2  = sat(plen_q, 2'd2);

	// Two-character operator formed by the held byte and this one.
	always_comb begin
		pair_v = 1'b1;
		pair_k = K_ASSIGN;
		if (held_q == ":" && c == "=") pair_k = K_ASSIGN;
		else if (held_q == "=" && c == ">") pair_k = K_ARROW;
		else if (held_q == "<" && c == "=") pair_k = K_LE;
		else if (held_q == ">" && c == "=") pair_k = K_GE;
		else if (held_q == "/" && c == "=") pair_k = K_NE;
		else pair_v = 1'b0;
	end

	// Token that the pending state stands for when it ends.
	always_comb begin
		fl_v   = 1'b1;
		fl_tok = '0;
		case (mode_q)
			MODE_IDENT: begin
				if (plen_q > LENGTH_BITS'(KEYWORD_CHARS))
					fl_tok = mk(K_IDENT, pstart_q, plen_q, E_NONE);
				else
					fl_tok = mk(kw_kind(64'(prefix_q), plen_q[3:0]), pstart_q, plen_q,
						E_NONE);
			end
			MODE_INT:    fl_tok = mk(K_INT, pstart_q, plen_q, E_NONE);
			MODE_INTDOT: fl_tok = mk(K_ERROR, pstart_q, '0, E_NUMBER);
			MODE_REAL:   fl_tok = mk(K_REAL, pstart_q, plen_q, E_NONE);
			MODE_STR:    fl_tok = mk(K_ERROR, pstart_q, '0, E_STRING);
			MODE_OP: begin
				if (held_q == ":") fl_tok = mk(K_ERROR, pstart_q, '0, E_OPER);
				else fl_tok = mk(single_kind(held_q), pstart_q, LENGTH_BITS'(1), E_NONE);
			end
			MODE_DOT:    fl_tok = mk(K_DOT, pstart_q, LENGTH_BITS'(1), E_NONE);
			default:     fl_v = 1'b0;
		endcase
	end

	// Handling of a byte that starts from the idle mode.
	always_comb begin
		id_v    = 1'b1;
		id_mode = MODE_IDLE;
		id_tok  = mk(K_NEWLINE, off_q, LENGTH_BITS'(1), E_NONE);
		case (c)
			" ", 8'h09: id_v = 1'b0;
			8'h0a: id_tok = mk(K_NEWLINE, off_q, LENGTH_BITS'(1), E_NONE);
			";": id_tok = mk(K_SEMI, off_q, LENGTH_BITS'(1), E_NONE);
			"+": id_tok = mk(K_PLUS, off_q, LENGTH_BITS'(1), E_NONE);
			"-": id_tok = mk(K_MINUS, off_q, LENGTH_BITS'(1), E_NONE);
			"*": id_tok = mk(K_STAR, off_q, LENGTH_BITS'(1), E_NONE);
			"(": id_tok = mk(K_LPAREN, off_q, LENGTH_BITS'(1), E_NONE);
			")": id_tok = mk(K_RPAREN, off_q, LENGTH_BITS'(1), E_NONE);
			"[": id_tok = mk(K_LBRACK, off_q, LENGTH_BITS'(1), E_NONE);
			"]": id_tok = mk(K_RBRACK, off_q, LENGTH_BITS'(1), E_NONE);
			"{": id_tok = mk(K_LBRACE, off_q, LENGTH_BITS'(1), E_NONE);
			"}": id_tok = mk(K_RBRACE, off_q, LENGTH_BITS'(1), E_NONE);
			",": id_tok = mk(K_COMMA, off_q, LENGTH_BITS'(1), E_NONE);
			default: begin
				id_v = 1'b0;
				if (c == 8'h22 || c == 8'h27) id_mode = MODE_STR;
				else if (is_dig) id_mode = MODE_INT;
				else if (is_alp) id_mode = MODE_IDENT;
				else if (c == ":" || c == "=" || c == "<" || c == ">" || c == "/")
					id_mode = MODE_OP;
				else if (c == ".") id_mode = MODE_DOT;
				else begin
					id_mode = MODE_ERR;
					id_v    = 1'b1;
					id_tok  = mk(K_ERROR, off_q, '0, E_CHAR);
				end
			end
		endcase
	end

	// Next state and the tokens of this byte.
	always_comb begin
		mode_d    = mode_q;
		held_d    = held_q;
		prefix_d  = prefix_q;
		plen_d    = plen_q;
		pstart_d  = pstart_q;
		off_d     = off_q + OFFSET_BITS'(1);
		a_v       = 1'b0;
		a_tok     = fl_tok;
		b_v       = 1'b0;
		b_tok     = id_tok;
		take_idle = 1'b0;
		if (end_of_source) begin
			a_v      = fl_v;
			b_v      = 1'b1;
			b_tok    = mk(K_EOF, off_q, '0, E_NONE);
			mode_d   = MODE_IDLE;
			held_d   = '0;
			prefix_d = '0;
			plen_d   = '0;
			pstart_d = '0;
			off_d    = '0;
		end else begin
			case (mode_q)
				MODE_IDLE: take_idle = 1'b1;
				MODE_IDENT: begin
					if (is_alp || is_dig) begin
						if (plen_q < LENGTH_BITS'(KEYWORD_CHARS))
							prefix_d = {prefix_q[PFX_W-9:0], c};
						plen_d = plen1;
					end else begin
						a_v = 1'b1;
						take_idle = 1'b1;
					end
				end
				MODE_INT: begin
					if (is_dig) plen_d = plen1;
					else if (c == ".") mode_d = MODE_INTDOT;
					else begin
						a_v = 1'b1;
						take_idle = 1'b1;
					end
				end
				MODE_INTDOT: begin
					if (c == ".") begin
						a_v    = 1'b1;
						a_tok  = mk(K_INT, pstart_q, plen_q, E_NONE);
						b_v    = 1'b1;
						b_tok  = mk(K_RANGE, off_q - OFFSET_BITS'(1), LENGTH_BITS'(2), E_NONE);
						mode_d = MODE_IDLE;
					end else if (is_dig) begin
						plen_d = plen2;
						mode_d = MODE_REAL;
					end else begin
						a_v    = 1'b1;
						mode_d = MODE_ERR;
					end
				end
				MODE_REAL: begin
					if (is_dig) plen_d = plen1;
					else if (c == ".") begin
						a_v    = 1'b1;
						a_tok  = mk(K_ERROR, pstart_q, '0, E_NUMBER);
						mode_d = MODE_ERR;
					end else begin
						a_v = 1'b1;
						take_idle = 1'b1;
					end
				end
				MODE_STR: begin
					plen_d = plen1;
					if (c == held_q) begin
						a_v    = 1'b1;
						a_tok  = mk(K_STRING, pstart_q, plen1, E_NONE);
						mode_d = MODE_IDLE;
					end
				end
				MODE_OP: begin
					if (pair_v) begin
						a_v    = 1'b1;
						a_tok  = mk(pair_k, pstart_q, LENGTH_BITS'(2), E_NONE);
						mode_d = MODE_IDLE;
					end else if (held_q == ":") begin
						a_v    = 1'b1;
						mode_d = MODE_ERR;
					end else begin
						a_v = 1'b1;
						take_idle = 1'b1;
					end
				end
				MODE_DOT: begin
					if (c == ".") begin
						a_v    = 1'b1;
						a_tok  = mk(K_RANGE, pstart_q, LENGTH_BITS'(2), E_NONE);
						mode_d = MODE_IDLE;
					end else begin
						a_v = 1'b1;
						take_idle = 1'b1;
					end
				end
				MODE_ERR: mode_d = MODE_ERR;
				default:  mode_d = MODE_IDLE;
			endcase
			if (take_idle) begin
				mode_d   = id_mode;
				pstart_d = off_q;
				plen_d   = LENGTH_BITS'(1);
				held_d   = c;
				prefix_d = PFX_W'(c);
				b_v      = id_v;
			end
		end
	end

	// Pack the tokens in order of appearance.
	always_comb begin
		push_tok1 = b_tok;
		if (a_v) begin
			push_tok0 = a_tok;
			push_cnt  = b_v ? 2'd2 : 2'd1;
		end else begin
			push_tok0 = b_tok;
			push_cnt  = b_v ? 2'd1 : 2'd0;
		end
		push = in_accept && (push_cnt != 2'd0);
	end

	// Scanner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			held_q   <= '0;
			prefix_q <= '0;
			plen_q   <= '0;
			pstart_q <= '0;
			off_q    <= '0;
		end else if (in_accept) begin
			mode_q   <= mode_d;
			held_q   <= held_d;
			prefix_q <= prefix_d;
			plen_q   <= plen_d;
			pstart_q <= pstart_d;
			off_q    <= off_d;
		end
	end

endmodule
`default_nettype wire

[sv/stt_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_queue: token pair queue
// A short queue of token groups between the scanner and the output side.
// ----------------------------------------------------------------------------
module stt_queue #(
	parameter int ENTRY_W = 8,
	parameter int DEPTH   = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [ENTRY_W-1:0] wr_data,
	input  wire logic               rd_en,
	output logic [ENTRY_W-1:0]      rd_data,
	output logic                    empty,
	output logic                    full
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [ENTRY_W-1:0] mem_q [DEPTH];
	logic [AW-1:0]      wp_q, rp_q;
	logic [AW:0]        cnt_q;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign rd_data = mem_q[rp_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (rd_en) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			if (wr_en && !rd_en) cnt_q <= cnt_q + (AW+1)'(1);
			else if (rd_en && !wr_en) cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

endmodule
`default_nettype wire

[sv/stt_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_back: token output stage
// Takes token groups from the queue and hands them out one per request,
// marking the last token of each group.
// ----------------------------------------------------------------------------
module stt_back #(
	parameter int TOK_W = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire logic [TOK_W*2+1:0] q_data,
	output logic                    q_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [TOK_W-1:0]        out_tok,
	output logic                    out_last
);
	logic             valid_q, last_q, has2_q;
	logic [TOK_W-1:0] cur_q, sec_q;
	logic [1:0]       q_cnt;
	logic             free;

	assign q_cnt     = q_data[TOK_W*2+1:TOK_W*2];
	assign free      = !valid_q || (out_ready && !has2_q);
	assign q_pop     = free && !q_empty;
	assign out_valid = valid_q;
	assign out_tok   = cur_q;
	assign out_last  = last_q;

	// Control of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			has2_q  <= 1'b0;
		end else if (valid_q && out_ready && has2_q) begin
			has2_q <= 1'b0;
			last_q <= 1'b1;
		end else if (free) begin
			valid_q <= !q_empty;
			has2_q  <= q_cnt == 2'd2;
			last_q  <= q_cnt != 2'd2;
		end
	end

	// Token payload.
	always_ff @(posedge clk) begin
		if (valid_q && out_ready && has2_q) begin
			cur_q <= sec_q;
		end else if (q_pop) begin
			cur_q <= q_data[TOK_W-1:0];
			sec_q <= q_data[TOK_W*2-1:TOK_W];
		end
	end

endmodule
`default_nettype wire

[sv/source_text_tokenizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexical analyzer
// Turns a stream of source bytes into tokens with kind, start and length.
// ----------------------------------------------------------------------------
// One source byte enters per cycle while the four-entry token queue has room;
// a byte that yields two tokens (a flushed token plus the next one) is handed
// out as two tokens, one per sink request, so the sustained rate is one byte
// per cycle as long as the sink keeps up and such bytes are rare. A token is
// offered once the output register loads it: the scanner writes the queue at
// the edge that accepts the byte completing it, and the output register loads
// from the queue whenever it is free. Most tokens are completed only by the
// byte after them; send an end-of-source request to flush the last one.
// After an error, bytes are dropped until end-of-source.
module source_text_tokenizer #(
	parameter int OFFSET_BITS   = 24,
	parameter int LENGTH_BITS   = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] char_byte
	input  wire logic [0:0] s_tuser,   // [0] end_of_source
	output logic      m_tvalid,
	input  wire logic m_tready,
	// token_kind, token_start, token_length, error_code from bit 0 up
	output logic [((stt_pkg::KIND_W + OFFSET_BITS + LENGTH_BITS + stt_pkg::ERR_W + 7)
		/ 8) * 8 - 1:0] m_tdata,
	output logic      m_tlast
);
	import stt_pkg::*;

	localparam int TOK_W = KIND_W + OFFSET_BITS + LENGTH_BITS + ERR_W;
	localparam int OUT_W = ((TOK_W + 7) / 8) * 8;
	localparam int ENT_W = 2 * TOK_W + 2;

	logic             in_accept, push, q_empty, q_full, q_pop;
	logic [1:0]       push_cnt;
	logic [TOK_W-1:0] tok0, tok1, out_tok;
	logic [ENT_W-1:0] q_rd;

	assign s_tready  = !q_full;
	assign in_accept = s_tvalid && s_tready;

	// Scanner.
	stt_front #(
		.OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS),
		.KEYWORD_CHARS(KEYWORD_CHARS), .TOK_W(TOK_W)
	) u_front (
		.clk(clk), .arst_n(arst_n), .in_accept(in_accept),
		.char_byte(s_tdata[7:0]), .end_of_source(s_tuser[0]),
		.push(push), .push_cnt(push_cnt), .push_tok0(tok0), .push_tok1(tok1)
	);

	// Queue of token groups.
	stt_queue #(.ENTRY_W(ENT_W), .DEPTH(4)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(push), .wr_data({push_cnt, tok1, tok0}),
		.rd_en(q_pop), .rd_data(q_rd), .empty(q_empty), .full(q_full)
	);

	// Output stage.
	stt_back #(.TOK_W(TOK_W)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(q_rd), .q_pop(q_pop),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_tok(out_tok), .out_last(m_tlast)
	);

	assign m_tdata = OUT_W'(out_tok);

endmodule
`default_nettype wire

[sv/stt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_checker: port checks of the tokenizer
// Watches the token output and flags handshake or field slips.
// ----------------------------------------------------------------------------
module stt_checker #(
	parameter int OFFSET_BITS = 24,
	parameter int LENGTH_BITS = 16,
	parameter int OUT_W       = 56
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata,
	input wire logic             m_tlast
);
	import stt_pkg::*;

	localparam int LEN_LO = KIND_W + OFFSET_BITS;
	localparam int ERR_LO = LEN_LO + LENGTH_BITS;

	// A stalled token stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("token dropped while stalled");

	// Error tokens carry no length.
	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[KIND_W-1:0] == K_ERROR |-> m_tdata[LEN_LO +: LENGTH_BITS] == '0)
		else $error("error token with length");

	// An error code comes with the error kind and only there.
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[KIND_W-1:0] == K_ERROR) == (m_tdata[ERR_LO +: ERR_W] != '0)))
		else $error("error code and kind disagree");

	// End of file closes the byte's group.
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[KIND_W-1:0] == K_EOF |-> m_tlast)
		else $error("end of file not last");

endmodule

bind source_text_tokenizer stt_checker #(
	.OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS),
	.OUT_W(((stt_pkg::KIND_W + OFFSET_BITS + LENGTH_BITS + stt_pkg::ERR_W + 7) / 8) * 8)
) u_stt_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

[sim/token_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_checker: token stream predictor and comparator
// Watches the byte and token channels of the tokenizer, predicts the tokens
// that each accepted request causes and compares them with the tokens seen.
// ----------------------------------------------------------------------------
module token_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
	input  wire logic [0:0]  s_tuser,   // [0] end_of_source
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	// token_kind, token_start, token_length, error_code from bit 0 up
	input  wire logic [55:0] m_tdata,
	input  wire logic        m_tlast,
	output int               pending_tokens,
	output int               fail_count
);
	import stt_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [23:0]       start;
		logic [15:0]       len;
		logic [ERR_W-1:0]  err;
		logic              last;
	} token_t;

	token_t expected_tokens[$];
	token_t step_tokens[$];

	// Scanner state of the predictor.
	mode_t       mode;
	logic [7:0]  quote_or_op;
	logic [47:0] word_prefix;
	logic [15:0] tok_len;
	logic [23:0] tok_start;
	logic [23:0] offset;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic [15:0] sat_add(input logic [15:0] l, input int d);
		logic [16:0] s;
		s = {1'b0, l} + 17'(d);
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic void put_token(input logic [KIND_W-1:0] k, input logic [23:0] s,
			input logic [15:0] l, input logic [ERR_W-1:0] e);
		token_t t;
		t = '{k, s, l, e, 1'b0};
		if (step_tokens.size() < 2) step_tokens.insert(step_tokens.size(), t);
	endfunction

	// Identifiers up to six bytes long may be keywords.
	function automatic logic [KIND_W-1:0] word_kind();
		if (tok_len > 16'd6) return K_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (16'(KW_LEN[i]) == tok_len && KW_TEXT[i] == {16'd0, word_prefix})
				return KIND_W'(i);
		end
		return K_IDENT;
	endfunction

	function automatic logic [KIND_W-1:0] single_op(input logic [7:0] a);
		case (a)
			"<": return K_LT;
			">": return K_GT;
			"=": return K_EQ;
			default: return K_SLASH;
		endcase
	endfunction

	// Two-character operators; returns 0 when the pair is not one.
	function automatic logic pair_op(input logic [7:0] a, input logic [7:0] b,
			output logic [KIND_W-1:0] k);
		k = K_ASSIGN;
		if (a == ":" && b == "=") k = K_ASSIGN;
		else if (a == "=" && b == ">") k = K_ARROW;
		else if (a == "<" && b == "=") k = K_LE;
		else if (a == ">" && b == "=") k = K_GE;
		else if (a == "/" && b == "=") k = K_NE;
		else return 1'b0;
		return 1'b1;
	endfunction

	// A byte seen with no token in progress.
	function automatic void open_token(input logic [7:0] c);
		logic [23:0] at;
		at = offset;
		mode = MODE_IDLE;
		case (c)
			" ", "\t": return;
			"\n": begin put_token(K_NEWLINE, at, 1, E_NONE); return; end
			";": begin put_token(K_SEMI, at, 1, E_NONE); return; end
			"+": begin put_token(K_PLUS, at, 1, E_NONE); return; end
			"-": begin put_token(K_MINUS, at, 1, E_NONE); return; end
			"*": begin put_token(K_STAR, at, 1, E_NONE); return; end
			"(": begin put_token(K_LPAREN, at, 1, E_NONE); return; end
			")": begin put_token(K_RPAREN, at, 1, E_NONE); return; end
			"[": begin put_token(K_LBRACK, at, 1, E_NONE); return; end
			"]": begin put_token(K_RBRACK, at, 1, E_NONE); return; end
			"{": begin put_token(K_LBRACE, at, 1, E_NONE); return; end
			"}": begin put_token(K_RBRACE, at, 1, E_NONE); return; end
			",": begin put_token(K_COMMA, at, 1, E_NONE); return; end
			default: ;
		endcase
		tok_start = at;
		tok_len = 16'd1;
		if (c == "\"" || c == "'") begin
			mode = MODE_STR;
			quote_or_op = c;
		end else if (is_digit(c)) begin
			mode = MODE_INT;
		end else if (is_alpha(c)) begin
			mode = MODE_IDENT;
			word_prefix = {40'd0, c};
		end else if (c == ":" || c == "=" || c == "<" || c == ">" || c == "/") begin
			mode = MODE_OP;
			quote_or_op = c;
		end else if (c == ".") begin
			mode = MODE_DOT;
		end else begin
			mode = MODE_ERR;
			put_token(K_ERROR, at, 0, E_CHAR);
		end
	endfunction

	// Reports the token in progress, as done by a terminating byte.
	function automatic void close_token();
		case (mode)
			MODE_IDENT: put_token(word_kind(), tok_start, tok_len, E_NONE);
			MODE_INT: put_token(K_INT, tok_start, tok_len, E_NONE);
			MODE_INTDOT: put_token(K_ERROR, tok_start, 0, E_NUMBER);
			MODE_REAL: put_token(K_REAL, tok_start, tok_len, E_NONE);
			MODE_STR: put_token(K_ERROR, tok_start, 0, E_STRING);
			MODE_OP: begin
				if (quote_or_op == ":") put_token(K_ERROR, tok_start, 0, E_OPER);
				else put_token(single_op(quote_or_op), tok_start, 1, E_NONE);
			end
			MODE_DOT: put_token(K_DOT, tok_start, 1, E_NONE);
			default: ;
		endcase
	endfunction

	function automatic void clear_scanner();
		mode = MODE_IDLE;
		quote_or_op = '0;
		word_prefix = '0;
		tok_len = '0;
		tok_start = '0;
		offset = '0;
	endfunction

	// Predicts the tokens of one request and queues them.
	function automatic void scan_request(input logic [7:0] c, input logic eos);
		logic [KIND_W-1:0] k;
		step_tokens.delete();
		if (eos) begin
			close_token();
			put_token(K_EOF, offset, 0, E_NONE);
			clear_scanner();
		end else begin
			case (mode)
				MODE_IDLE: open_token(c);
				MODE_IDENT: begin
					if (is_alpha(c) || is_digit(c)) begin
						if (tok_len < 16'd6) word_prefix = {word_prefix[39:0], c};
						tok_len = sat_add(tok_len, 1);
					end else begin
						close_token();
						open_token(c);
					end
				end
				MODE_INT: begin
					if (is_digit(c)) tok_len = sat_add(tok_len, 1);
					else if (c == ".") mode = MODE_INTDOT;
					else begin
						close_token();
						open_token(c);
					end
				end
				MODE_INTDOT: begin
					if (c == ".") begin
						put_token(K_INT, tok_start, tok_len, E_NONE);
						put_token(K_RANGE, offset - 24'd1, 2, E_NONE);
						mode = MODE_IDLE;
					end else if (is_digit(c)) begin
						tok_len = sat_add(tok_len, 2);
						mode = MODE_REAL;
					end else begin
						put_token(K_ERROR, tok_start, 0, E_NUMBER);
						mode = MODE_ERR;
					end
				end
				MODE_REAL: begin
					if (is_digit(c)) tok_len = sat_add(tok_len, 1);
					else if (c == ".") begin
						put_token(K_ERROR, tok_start, 0, E_NUMBER);
						mode = MODE_ERR;
					end else begin
						close_token();
						open_token(c);
					end
				end
				MODE_STR: begin
					tok_len = sat_add(tok_len, 1);
					if (c == quote_or_op) begin
						put_token(K_STRING, tok_start, tok_len, E_NONE);
						mode = MODE_IDLE;
					end
				end
				MODE_OP: begin
					if (pair_op(quote_or_op, c, k)) begin
						put_token(k, tok_start, 2, E_NONE);
						mode = MODE_IDLE;
					end else if (quote_or_op == ":") begin
						put_token(K_ERROR, tok_start, 0, E_OPER);
						mode = MODE_ERR;
					end else begin
						close_token();
						open_token(c);
					end
				end
				MODE_DOT: begin
					if (c == ".") begin
						put_token(K_RANGE, tok_start, 2, E_NONE);
						mode = MODE_IDLE;
					end else begin
						close_token();
						open_token(c);
					end
				end
				MODE_ERR: ;
				default: mode = MODE_IDLE;
			endcase
			offset = offset + 24'd1;
		end
		if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
	endfunction

	// Predict on each accepted request, compare each accepted token.
	always @(posedge clk or negedge arst_n) begin
		token_t exp_tok;
		if (!arst_n) begin
			clear_scanner();
			expected_tokens.delete();
			fail_count = 0;
		end else begin
			if (s_tvalid && s_tready) scan_request(s_tdata, s_tuser[0]);
			if (m_tvalid && m_tready) begin
				if (expected_tokens.size() == 0) begin
					$error("token with no expectation: kind %0d start %0d",
						m_tdata[5:0], m_tdata[29:6]);
					fail_count++;
				end else begin
					exp_tok = expected_tokens.pop_front();
					if (m_tdata[5:0] != exp_tok.kind) begin
						$error("token_kind: expected %0d, actual %0d", exp_tok.kind, m_tdata[5:0]);
						fail_count++;
					end
					if (m_tdata[29:6] != exp_tok.start) begin
						$error("token_start: expected %0d, actual %0d", exp_tok.start,
							m_tdata[29:6]);
						fail_count++;
					end
					if (m_tdata[45:30] != exp_tok.len) begin
						$error("token_length: expected %0d, actual %0d", exp_tok.len,
							m_tdata[45:30]);
						fail_count++;
					end
					if (m_tdata[48:46] != exp_tok.err) begin
						$error("error_code: expected %0d, actual %0d", exp_tok.err,
							m_tdata[48:46]);
						fail_count++;
					end
					if (m_tlast != exp_tok.last) begin
						$error("last_of_item: expected %0d, actual %0d", exp_tok.last, m_tlast);
						fail_count++;
					end
				end
			end
		end
		pending_tokens = expected_tokens.size();
	end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the source text tokenizer
// Feeds directed and random source texts with varied flow control and lets
// the token checker judge every token.
// ----------------------------------------------------------------------------
module tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tlast;
	int          pending_tokens;
	int          fail_count;

	int          send_idle_pct = 0;
	int          sink_stall_pct = 0;
	logic        hold_toggle = 1'b0;
	int          bytes_sent = 0;
	logic [7:0]  text_q[$];

	string keywords[25] = '{"var", "is", "if", "then", "else", "end", "while", "for",
		"in", "loop", "exit", "print", "return", "or", "and", "xor", "not", "int",
		"real", "bool", "string", "func", "true", "false", "none"};
	string punct[23] = '{":=", "=>", "<", "<=", ">", ">=", "=", "/=", "+", "-", "*",
		"/", "..", ".", "(", ")", "[", "]", "{", "}", ",", ";", "\n"};

	always #2 clk = ~clk;

	source_text_tokenizer i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	token_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.pending_tokens(pending_tokens), .fail_count(fail_count)
	);

	// Sink side: random stalls, plus a long hold-off on each toggle request.
	initial begin
		logic seen;
		int   hold_left;
		seen = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_toggle != seen) begin
				seen = hold_toggle;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Offers one request and waits for its acceptance.
	task automatic send_request(input logic [7:0] c, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tuser <= eos;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// Appends one byte to the pending source text.
	function automatic void add_byte(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	// Sends the queued text followed by the end-of-source marker.
	task automatic send_source();
		foreach (text_q[i]) send_request(text_q[i], 1'b0);
		send_request(8'($urandom), 1'b1);
		text_q.delete();
	endtask

	task automatic add_digits();
		int n;
		n = $urandom_range(1, 5);
		repeat (n) add_byte(8'("0") + 8'($urandom_range(9)));
	endtask

	// One random lexeme, mostly well formed, sometimes noise.
	task automatic add_lexeme();
		int    n;
		string q;
		case ($urandom_range(19))
			0, 1, 2: add_text(keywords[$urandom_range(24)]);
			3, 4: begin
				n = $urandom_range(1, 10);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(i == 0 ? 2 : 3))
						0: add_byte(8'("a") + 8'($urandom_range(25)));
						1: add_byte(8'("A") + 8'($urandom_range(25)));
						2: add_byte("_");
						default: add_byte(8'("0") + 8'($urandom_range(9)));
					endcase
				end
			end
			5, 6: add_digits();
			7: begin add_digits(); add_text("."); add_digits(); end
			8: begin add_digits(); add_text(".."); end
			9: begin
				add_digits();
				add_text(".");
				if ($urandom_range(1)) add_digits();
			end
			10, 11: begin
				q = $urandom_range(1) ? "\"" : "'";
				add_text(q);
				n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(3) == 0) add_byte(8'($urandom));
					else add_byte(8'("a") + 8'($urandom_range(25)));
				end
				if ($urandom_range(7) != 0) add_text(q);
			end
			12, 13, 14, 15: add_text(punct[$urandom_range(22)]);
			16: add_text($urandom_range(1) ? " " : "\t");
			17: add_text(":");
			default: add_byte(8'($urandom));
		endcase
		if ($urandom_range(1)) add_text($urandom_range(3) == 0 ? "\t" : " ");
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_tokens != 0);
	endtask

	// Random sources until the phase's share of bytes is sent.
	task automatic run_phase(input int idle_pct, input int stall_pct, input int target);
		send_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		while (bytes_sent < target) begin
			repeat ($urandom_range(3, 25)) add_lexeme();
			send_source();
		end
	endtask

	// Stimulus and verdict.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sources: ranges, operators, bad bytes, open tokens at the end.
		add_text("7..1.5<=x;");
		send_source();
		add_byte(8'hFF);
		send_source();
		add_byte(8'h00);
		send_source();
		add_text("'a");
		send_source();
		add_text(":");
		send_source();
		add_text("1.");
		send_source();

		run_phase(0, 0, 420);
		hold_toggle <= ~hold_toggle;
		run_phase(0, 0, 600);
		wait_drained();
		run_phase(70, 0, 900);
		run_phase(0, 70, 1200);
		run_phase(27, 27, 1550);

		wait_drained();
		repeat (30) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

endmodule

[source_text_tokenizer.f]
sv/stt_pkg.sv
sv/stt_front.sv
sv/stt_queue.sv
sv/stt_back.sv
sv/source_text_tokenizer.sv
sv/stt_checker.sv
sim/token_checker.sv
sim/tb.sv
